// File: src/comb_double_integrator_filter_unit_assert.svh
// assertion macros for the cascaded moving-sum filter
// no dependencies; taken in by the modules that carry checks
`ifndef COMB_DOUBLE_INTEGRATOR_FILTER_UNIT_ASSERT_SVH
`define COMB_DOUBLE_INTEGRATOR_FILTER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define CDIF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cdif check failed");

// next-cycle implication, disabled while reset is low
`define CDIF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cdif check failed");

`endif

// File: src/cdif_pkg.sv
// shared widths and types for the cascaded moving-sum filter
// no dependencies
`default_nettype none

package cdif_pkg;

    localparam int SAMPLE_W = 16;  // input sample and output result width
    localparam int DIFF_W   = 18;  // signed comb difference x - d1 - d2 + d3
    localparam int ACC_W    = 32;  // wrapping integrator width

    typedef logic [SAMPLE_W-1:0]      t_sample;
    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic [ACC_W-1:0]         t_acc;

endpackage

`default_nettype wire

// File: src/cdif_cell.sv
// one 16-bit delay cell of the sample shift line
// depends on cdif_pkg
`default_nettype none

module cdif_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_shift,
    input  cdif_pkg::t_sample i_d,
    output cdif_pkg::t_sample o_q
);

    cdif_pkg::t_sample r_q;
    cdif_pkg::t_sample n_q;

    always_comb begin
        n_q = i_shift ? i_d : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;

endmodule

`default_nettype wire

// File: src/cdif_integ.sv
// one wrapping 32-bit integrator stage with its own valid/ready slot
// depends on cdif_pkg and the assertion macro header
`default_nettype none
`include "comb_double_integrator_filter_unit_assert.svh"

module cdif_integ (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    input  cdif_pkg::t_acc i_data,
    output logic           o_ready,
    output logic           o_valid,
    output cdif_pkg::t_acc o_acc,
    input  wire            i_ready
);

    logic           r_valid;
    logic           n_valid;
    cdif_pkg::t_acc r_acc;
    cdif_pkg::t_acc n_acc;
    logic           w_load;

    // slot frees up when empty or when downstream takes the held value
    assign o_ready = !r_valid || i_ready;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_acc   = r_acc;
        n_valid = r_valid;
        if (w_load) begin
            n_acc   = r_acc + i_data;
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            r_valid <= n_valid;
            r_acc   <= n_acc;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;

    `CDIF_ASSERT_NOW(a_empty_is_ready, i_clk, i_rst_n, !o_valid, o_ready)
    `CDIF_ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, w_load, o_valid)
    `CDIF_ASSERT_NEXT(a_load_adds, i_clk, i_rst_n, w_load, o_acc == $past(o_acc) + $past(i_data))
    `CDIF_ASSERT_NEXT(a_idle_holds_acc, i_clk, i_rst_n, !w_load, $stable(o_acc))

endmodule

`default_nettype wire

// File: src/comb_double_integrator_filter_unit.sv
// cascaded 32/64-point moving-sum filter, top level
// depends on cdif_pkg, cdif_cell and cdif_integ
//
//   channel | valid   | ready   | payload            | direction
//   --------+---------+---------+--------------------+----------
//   input   | i_valid | o_ready | i_sample   [15:0]  | in
//   output  | o_valid | i_ready | o_filtered [15:0]  | out
//
// one sample per cycle sustained while the output is not stalled; a result is registered
// in the first integrator, then in the second (each stage a single 32-bit add)
// the comb part is a shift line of 3*SEG_LEN cells tapped at SEG_LEN, 2*SEG_LEN, 3*SEG_LEN
// synchronous active-low reset zeros every cell and both integrators
// a stalled output holds in the second integrator; the first stage still takes
// one more transaction, and o_ready drops only when both stages are full
`default_nettype none

module comb_double_integrator_filter_unit #(
    parameter int SEG_LEN     = 32,
    parameter int SCALE_SHIFT = 11
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [15:0]        i_sample,
    output logic               o_valid,
    input  wire                i_ready,
    output logic [15:0]        o_filtered
);

    localparam int DEPTH = 3 * SEG_LEN;

    // shift line taps: w_tap[k] holds x[n-k] once the new sample is at w_tap[0]
    cdif_pkg::t_sample w_tap [0:DEPTH];
    logic              w_accept;

    // comb difference and integrator links
    cdif_pkg::t_diff   w_diff;
    cdif_pkg::t_acc    w_diff_ext;
    logic              w_s1_valid;
    logic              w_s1_ready;
    cdif_pkg::t_acc    w_s1_acc;
    cdif_pkg::t_acc    w_y;

    assign w_accept = i_valid && o_ready;
    assign w_tap[0] = i_sample;

    // delay line: every accepted transaction moves all cells one place down
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            cdif_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_accept),
                .i_d     (w_tap[g]),
                .o_q     (w_tap[g+1])
            );
        end
    endgenerate

    // comb: x[n] - x[n-S] - x[n-2S] + x[n-3S], fits 18 bits signed
    always_comb begin
        w_diff = cdif_pkg::t_diff'({2'b00, w_tap[0]})
               - cdif_pkg::t_diff'({2'b00, w_tap[SEG_LEN]})
               - cdif_pkg::t_diff'({2'b00, w_tap[2*SEG_LEN]})
               + cdif_pkg::t_diff'({2'b00, w_tap[3*SEG_LEN]});
        w_diff_ext = {{(cdif_pkg::ACC_W - cdif_pkg::DIFF_W){w_diff[cdif_pkg::DIFF_W-1]}},
                      w_diff};
    end

    // first integrator: slope u[n] = u[n-1] + comb difference
    cdif_integ u_integ_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (w_diff_ext),
        .o_ready (o_ready),
        .o_valid (w_s1_valid),
        .o_acc   (w_s1_acc),
        .i_ready (w_s1_ready)
    );

    // second integrator: y[n] = y[n-1] + u[n], doubles as the output register
    cdif_integ u_integ_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_s1_valid),
        .i_data  (w_s1_acc),
        .o_ready (w_s1_ready),
        .o_valid (o_valid),
        .o_acc   (w_y),
        .i_ready (i_ready)
    );

    // scaled result: 16 bits starting at SCALE_SHIFT
    assign o_filtered = w_y[SCALE_SHIFT +: cdif_pkg::SAMPLE_W];

endmodule

`default_nettype wire

// File: tb/cdif_output_checker.sv
// checker for the cascaded moving-sum filter: watches both channels,
// predicts every result and compares it; depends on cdif_pkg
`timescale 1ns / 1ps

module cdif_output_checker #(
    parameter int SEG_LEN     = 32,
    parameter int SCALE_SHIFT = 11
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_ready,
    input  cdif_pkg::t_sample i_sample,
    input  wire               i_out_valid,
    input  wire               i_out_ready,
    input  cdif_pkg::t_sample i_filtered,
    output int                o_errors,
    output int                o_pending
);

    // predictor state
    cdif_pkg::t_sample taps [3*SEG_LEN];
    cdif_pkg::t_acc    y_prev;
    cdif_pkg::t_acc    y_prev2;
    int unsigned       tap_idx;

    cdif_pkg::t_sample expected_filtered [$];
    cdif_pkg::t_sample want;
    int                err_count = 0;

    assign o_errors = err_count;

    // one step of y = 2*y1 - y2 + x - d1 - d2 + d3, all mod 2^32
    function automatic cdif_pkg::t_sample predict_filtered(cdif_pkg::t_sample x);
        cdif_pkg::t_sample d1, d2, d3;
        cdif_pkg::t_acc    y;
        d1 = taps[tap_idx];
        d2 = taps[SEG_LEN + tap_idx];
        d3 = taps[2*SEG_LEN + tap_idx];
        taps[2*SEG_LEN + tap_idx] = d2;
        taps[SEG_LEN + tap_idx]   = d1;
        taps[tap_idx]             = x;
        y = (y_prev << 1) - y_prev2 + cdif_pkg::t_acc'(x)
            - cdif_pkg::t_acc'(d1) - cdif_pkg::t_acc'(d2) + cdif_pkg::t_acc'(d3);
        y_prev2 = y_prev;
        y_prev  = y;
        tap_idx = (tap_idx + 1) % SEG_LEN;
        return cdif_pkg::t_sample'(y >> SCALE_SHIFT);
    endfunction

    task automatic report_mismatch(string what, cdif_pkg::t_sample got,
                                   cdif_pkg::t_sample exp_val);
        err_count++;
        $display("[%0t] mismatch: %s, filtered got %h expected %h",
                 $time, what, got, exp_val);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3*SEG_LEN; k++) taps[k] = '0;
            y_prev  = '0;
            y_prev2 = '0;
            tap_idx = 0;
            expected_filtered.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_filtered.size() == 0) begin
                    report_mismatch("result with nothing outstanding", i_filtered, '0);
                end else begin
                    want = expected_filtered.pop_front();
                    if (i_filtered !== want)
                        report_mismatch("wrong value", i_filtered, want);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_filtered.push_back(predict_filtered(i_sample));
            o_pending <= expected_filtered.size();
        end
    end

endmodule

// File: tb/tb_top.sv
// top of the filter testbench: clock, reset, stimulus and verdict
// depends on cdif_pkg, comb_double_integrator_filter_unit and cdif_output_checker
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT  = 1000;  // cycles with no transaction at all
    localparam int HOLD_OFF_CYCLES = 40;    // long receiver stall
    localparam int DRAIN_CYCLES    = 8;     // settle time after the last result
    localparam int PHASE_ITEMS     = 540;

    // shapes of random sample runs
    typedef enum int {
        SEG_NOISE,       // uniform over the full range
        SEG_FULL_SCALE,  // constant max, drives the sums to full scale
        SEG_LEVEL,       // constant random level (step response)
        SEG_LOW,         // small values
        SEG_HIGH,        // near full scale with noise in the low bits
        SEG_TOGGLE       // alternating zero and max
    } t_seg_mode;

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              i_valid  = 1'b0;
    logic              i_ready  = 1'b0;
    cdif_pkg::t_sample i_sample = '0;
    logic              o_ready;
    logic              o_valid;
    cdif_pkg::t_sample o_filtered;

    int err_total;
    int outstanding;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_req;
    int quiet_cycles = 0;

    comb_double_integrator_filter_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_filtered (o_filtered)
    );

    cdif_output_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_sample    (i_sample),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_filtered  (o_filtered),
        .o_errors    (err_total),
        .o_pending   (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random back-pressure, or a long hold-off when asked for
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge i_clk);
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // offer one sample, with random idle cycles in front, and wait for the transaction;
    // valid is left high so a following sample goes out back to back
    task automatic send_sample(cdif_pkg::t_sample s);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // sender goes quiet until every outstanding result has been taken
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // runs of shaped samples; sustained high runs are what reach the top output bits
    task automatic send_segments(int unsigned count);
        int unsigned       sent;
        int unsigned       run_len;
        cdif_pkg::t_sample level;
        cdif_pkg::t_sample s;
        t_seg_mode         mode;
        sent = 0;
        while (sent < count) begin
            mode    = t_seg_mode'($urandom_range(SEG_TOGGLE));
            run_len = $urandom_range(20, 140);
            level   = cdif_pkg::t_sample'($urandom_range(16'hFFFF));
            for (int unsigned k = 0; k < run_len && sent < count; k++) begin
                case (mode)
                    SEG_NOISE:      s = cdif_pkg::t_sample'($urandom);
                    SEG_FULL_SCALE: s = '1;
                    SEG_LEVEL:      s = level;
                    SEG_LOW:        s = cdif_pkg::t_sample'($urandom_range(255));
                    SEG_HIGH:       s = 16'hF000 | cdif_pkg::t_sample'($urandom_range(16'h0FFF));
                    default:        s = k[0] ? '1 : '0;
                endcase
                send_sample(s);
                sent++;
            end
        end
    endtask

    initial begin
        cdif_pkg::t_sample directed [$];
        directed = '{16'h0000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
                     16'h7FFF, 16'hAAAA, 16'h5555};
        send_idle_pct = 33;
        recv_idle_pct = 45;
        hold_off_req  = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes and bit patterns, then a full-scale run
        foreach (directed[k]) send_sample(directed[k]);
        repeat (17) send_sample('1);

        // phase one: sender idles less than the receiver
        send_segments(PHASE_ITEMS / 2);
        hold_off_req = 1'b1;  // block fills up and stalls its input
        send_segments(PHASE_ITEMS / 2);

        // phase two: roles swapped, starting from an empty pipeline
        send_idle_pct = 45;
        recv_idle_pct = 33;
        wait_drained();
        send_segments(PHASE_ITEMS);

        // phase three: full rate both ways
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_segments(PHASE_ITEMS / 2);
        hold_off_req = 1'b1;
        send_segments(PHASE_ITEMS / 2);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_total == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
